// ----- hdl/numeric_for_loop_unit_assert.svh -----
// Assertion macros used by the checker of the numeric for-loop unit
`ifndef NUMERIC_FOR_LOOP_UNIT_ASSERT_SVH
`define NUMERIC_FOR_LOOP_UNIT_ASSERT_SVH

// Check cons in the same cycle as ante, outside reset.
`define NFLU_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante, outside reset.
`define NFLU_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Check cons in the cycle after reset is seen.
`define NFLU_ASSERT_RST(lbl, clk, rst, cons, msg) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

// ----- hdl/nflu_pkg.sv -----
// Types, codes, constants and float compare helpers of the numeric for-loop unit
package nflu_pkg;

   localparam int WORD_W       = 64;
   localparam int I2D_LAT      = 4;
   localparam int FADD_LAT     = 6;
   localparam int FRONT_STAGES = FADD_LAT;
   localparam int DIV_STAGES   = WORD_W;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [1:0]        tag_type;

   localparam tag_type TAG_INT  = 2'd0;
   localparam tag_type TAG_FLT  = 2'd1;
   localparam logic    CMD_PREP = 1'b0;
   localparam logic    CMD_STEP = 1'b1;

   typedef enum logic [2:0] {
      OUT_ENTER = 3'd0,
      OUT_SKIP  = 3'd1,
      OUT_BACK  = 3'd2,
      OUT_FALL  = 3'd3,
      OUT_REJ   = 3'd4
   } outcome_type;

   localparam logic [10:0] EXP_MAX  = 11'h7FF;
   localparam word_type    DBL_QNAN = 64'h7FF8_0000_0000_0000;

   typedef struct packed {
      logic     cmd;
      tag_type  tag0;
      word_type bits0;
      tag_type  tag1;
      word_type bits1;
      tag_type  tag2;
      word_type bits2;
   } item_type;

   typedef struct packed {
      outcome_type outcome;
      logic        use_quot;
      tag_type     tag0;
      word_type    bits0;
      tag_type     tag1;
      word_type    bits1;
      tag_type     tag2;
      word_type    bits2;
   } side_type;

   function automatic logic f_isnan(word_type x);
      return (x[62:52] == EXP_MAX) && (x[51:0] != 52'd0);
   endfunction

   function automatic logic f_iszero(word_type x);
      return x[62:0] == 63'd0;
   endfunction

   function automatic logic f_pos(word_type x);
      return !f_isnan(x) && !x[63] && !f_iszero(x);
   endfunction

   function automatic logic f_neg(word_type x);
      return !f_isnan(x) && x[63] && !f_iszero(x);
   endfunction

   function automatic logic f_lt(word_type a, word_type b);
      logic res;
      if (f_isnan(a) || f_isnan(b) || (f_iszero(a) && f_iszero(b))) begin
         res = 1'b0;
      end else if (a[63] != b[63]) begin
         res = a[63];
      end else if (!a[63]) begin
         res = a[62:0] < b[62:0];
      end else begin
         res = a[62:0] > b[62:0];
      end
      return res;
   endfunction

   function automatic logic f_eq(word_type a, word_type b);
      return !f_isnan(a) && !f_isnan(b) &&
             ((a == b) || (f_iszero(a) && f_iszero(b)));
   endfunction

endpackage

// ----- hdl/nflu_intf.sv -----
// Request and response channel interfaces of the numeric for-loop unit
interface nflu_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [1:0]  cell0_tag;
   logic [63:0] cell0_bits;
   logic [1:0]  cell1_tag;
   logic [63:0] cell1_bits;
   logic [1:0]  cell2_tag;
   logic [63:0] cell2_bits;

   modport source (output valid, cmd, cell0_tag, cell0_bits, cell1_tag, cell1_bits,
                   cell2_tag, cell2_bits, input ready);
   modport sink (input valid, cmd, cell0_tag, cell0_bits, cell1_tag, cell1_bits,
                 cell2_tag, cell2_bits, output ready);
endinterface

interface nflu_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  outcome;
   logic [1:0]  new0_tag;
   logic [63:0] new0_bits;
   logic [1:0]  new1_tag;
   logic [63:0] new1_bits;
   logic [1:0]  new2_tag;
   logic [63:0] new2_bits;

   modport source (output valid, outcome, new0_tag, new0_bits, new1_tag, new1_bits,
                   new2_tag, new2_bits, input ready);
   modport sink (input valid, outcome, new0_tag, new0_bits, new1_tag, new1_bits,
                 new2_tag, new2_bits, output ready);
endinterface

// ----- hdl/numeric_for_loop_unit.sv -----
// Top level of the numeric for-loop unit: skid, front pipeline, decision and divider
//
//   channel   dir   handshake       payload
//   req_chan  in    valid / ready   cmd, cell0..2 tag and bits
//   rsp_chan  out   valid / ready   outcome, new0..2 tag and bits
//
// One word enters per cycle unless a stalled response holds the pipeline. The
// depth is set by the 64-stage quotient pipeline, one bit per stage, behind
// the six-stage double adder that sets the front.
// A stalled response freezes the whole pipeline; a one-word skid at the input
// still takes one word while the response waits, then drops ready.
// Synchronous reset clears the valid bits and the skid; data registers keep junk.
module numeric_for_loop_unit import nflu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   nflu_req_if.sink   req_chan,
   nflu_rsp_if.source rsp_chan
);

   localparam int LAST    = FRONT_STAGES - 1;
   localparam int I2D_TAP = FRONT_STAGES - 1 - I2D_LAT;

   // input skid
   logic     skid_vld_ff;
   item_type skid_ff;
   item_type req_item;
   logic     pipe_vld;
   item_type pipe_item;
   logic     adv;

   // front pipeline, raw word travels beside the arithmetic units
   logic [FRONT_STAGES-1:0] raw_vld_ff;
   item_type                raw_ff [FRONT_STAGES];
   word_type                fsum;
   word_type                cnv0, cnv1, cnv2;

   // decision stage
   item_type cur;
   side_type side;
   word_type div_num, div_den;
   logic     all_int, all_num;
   logic     isv_zero, isv_pos, isv_neg;
   word_type fiv, flv, fsv;

   // divider output
   logic     div_vld;
   word_type div_quot;
   side_type div_side;

   assign req_item = '{cmd:   req_chan.cmd,
                       tag0:  req_chan.cell0_tag, bits0: req_chan.cell0_bits,
                       tag1:  req_chan.cell1_tag, bits1: req_chan.cell1_bits,
                       tag2:  req_chan.cell2_tag, bits2: req_chan.cell2_bits};

   // Advance whenever the last stage is empty or its word is being taken.
   assign adv            = !div_vld || rsp_chan.ready;
   assign req_chan.ready = !skid_vld_ff;
   assign pipe_vld       = skid_vld_ff || req_chan.valid;
   assign pipe_item      = skid_vld_ff ? skid_ff : req_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_vld_ff <= 1'b0;
      end else if (adv) begin
         skid_vld_ff <= 1'b0;
      end else if (req_chan.valid && req_chan.ready) begin
         skid_vld_ff <= 1'b1;
      end
   end

   // Hold the word that arrives while the pipeline is frozen.
   always_ff @(posedge clock) begin
      if (!adv && req_chan.valid && req_chan.ready) begin
         skid_ff <= req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_vld_ff <= '0;
      end else if (adv) begin
         raw_vld_ff <= {raw_vld_ff[FRONT_STAGES-2:0], pipe_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         raw_ff[0] <= pipe_item;
         for (int k = 1; k < FRONT_STAGES; k++) begin
            raw_ff[k] <= raw_ff[k-1];
         end
      end
   end

   // Index plus step for the float step; lands with raw_ff[LAST].
   nflu_fadd u_fadd (
      .clock (clock),
      .en    (adv),
      .a     (pipe_item.bits2),
      .b     (pipe_item.bits1),
      .sum   (fsum)
   );

   // Integer cells converted to double for the mixed prepare; tapped late so
   // that the result lands with raw_ff[LAST] as well.
   nflu_i2d u_i2d0 (.clock(clock), .en(adv), .int_val(raw_ff[I2D_TAP].bits0), .dbl_val(cnv0));
   nflu_i2d u_i2d1 (.clock(clock), .en(adv), .int_val(raw_ff[I2D_TAP].bits1), .dbl_val(cnv1));
   nflu_i2d u_i2d2 (.clock(clock), .en(adv), .int_val(raw_ff[I2D_TAP].bits2), .dbl_val(cnv2));

   // Decide the outcome and the new cells; the count itself comes out of the divider.
   always_comb begin
      cur      = raw_ff[LAST];
      side     = '{outcome: OUT_REJ, use_quot: 1'b0,
                   tag0: cur.tag0, bits0: cur.bits0,
                   tag1: cur.tag1, bits1: cur.bits1,
                   tag2: cur.tag2, bits2: cur.bits2};
      all_int  = cur.tag0 == TAG_INT && cur.tag1 == TAG_INT && cur.tag2 == TAG_INT;
      all_num  = (cur.tag0 == TAG_INT || cur.tag0 == TAG_FLT) &&
                 (cur.tag1 == TAG_INT || cur.tag1 == TAG_FLT) &&
                 (cur.tag2 == TAG_INT || cur.tag2 == TAG_FLT);
      isv_zero = cur.bits2 == '0;
      isv_pos  = !cur.bits2[WORD_W-1] && !isv_zero;
      isv_neg  = cur.bits2[WORD_W-1];
      fiv      = (cur.tag0 == TAG_INT) ? cnv0 : cur.bits0;
      flv      = (cur.tag1 == TAG_INT) ? cnv1 : cur.bits1;
      fsv      = (cur.tag2 == TAG_INT) ? cnv2 : cur.bits2;
      // distance over stride, both taken along the step direction
      div_num  = isv_neg ? (cur.bits0 - cur.bits1) : (cur.bits1 - cur.bits0);
      div_den  = isv_neg ? (~cur.bits2 + 64'd1) : cur.bits2;

      case (cur.cmd)
         CMD_PREP: begin
            if (all_int) begin
               if (isv_zero) begin
                  side.outcome = OUT_REJ;
               end else if ((isv_pos && $signed(cur.bits0) > $signed(cur.bits1)) ||
                            (isv_neg && $signed(cur.bits0) < $signed(cur.bits1))) begin
                  side.outcome = OUT_SKIP;
               end else begin
                  side.outcome  = OUT_ENTER;
                  side.use_quot = 1'b1;
                  side.bits1    = cur.bits2;
                  side.bits2    = cur.bits0;
                  side.tag0     = TAG_INT;
                  side.tag1     = TAG_INT;
                  side.tag2     = TAG_INT;
               end
            end else if (all_num) begin
               if (f_iszero(fsv)) begin
                  side.outcome = OUT_REJ;
               end else if ((f_pos(fsv) && f_lt(flv, fiv)) ||
                            (f_neg(fsv) && f_lt(fiv, flv))) begin
                  side.outcome = OUT_SKIP;
               end else begin
                  side.outcome = OUT_ENTER;
                  side.bits0   = flv;
                  side.bits1   = fsv;
                  side.bits2   = fiv;
                  side.tag0    = TAG_FLT;
                  side.tag1    = TAG_FLT;
                  side.tag2    = TAG_FLT;
               end
            end else begin
               side.outcome = OUT_REJ;
            end
         end
         CMD_STEP: begin
            if (cur.tag1 == TAG_INT) begin
               if (cur.bits0 != '0) begin
                  side.outcome = OUT_BACK;
                  side.bits0   = cur.bits0 - 64'd1;
                  side.bits2   = cur.bits2 + cur.bits1;
               end else begin
                  side.outcome = OUT_FALL;
               end
            end else if ((f_pos(cur.bits1) &&
                          (f_lt(fsum, cur.bits0) || f_eq(fsum, cur.bits0))) ||
                         (f_neg(cur.bits1) &&
                          (f_lt(cur.bits0, fsum) || f_eq(cur.bits0, fsum)))) begin
               side.outcome = OUT_BACK;
               side.bits2   = fsum;
            end else begin
               side.outcome = OUT_FALL;
            end
         end
         default: begin
            side.outcome = OUT_REJ;
         end
      endcase
   end

   nflu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (raw_vld_ff[LAST]),
      .dividend  (div_num),
      .divisor   (div_den),
      .in_side   (side),
      .out_valid (div_vld),
      .quotient  (div_quot),
      .out_side  (div_side)
   );

   // The last divider stage is the output register.
   assign rsp_chan.valid     = div_vld;
   assign rsp_chan.outcome   = div_side.outcome;
   assign rsp_chan.new0_tag  = div_side.tag0;
   assign rsp_chan.new0_bits = div_side.use_quot ? div_quot : div_side.bits0;
   assign rsp_chan.new1_tag  = div_side.tag1;
   assign rsp_chan.new1_bits = div_side.bits1;
   assign rsp_chan.new2_tag  = div_side.tag2;
   assign rsp_chan.new2_bits = div_side.bits2;

endmodule

// ----- hdl/nflu_i2d.sv -----
// Four-stage signed 64-bit integer to double conversion, round to nearest even
module nflu_i2d import nflu_pkg::*; (
   input  logic     clock,
   input  logic     en,
   input  word_type int_val,
   output word_type dbl_val
);

   localparam logic [10:0] EXP_TOP = 11'd1086;

   logic        sgn1_ff;
   word_type    mag1_ff;
   logic        sgn2_ff, zero2_ff, zero2_in;
   word_type    nrm2_ff, nrm2_in;
   logic [5:0]  lz2_ff, lz2_in;
   logic        sgn3_ff, zero3_ff;
   word_type    nrm3_ff, nrm3_in;
   logic [5:0]  lz3_ff, lz3_in;
   word_type    dbl4_ff, dbl4_in;
   logic [10:0] expo;
   logic        rnd;
   logic [62:0] body;

   // coarse normalize
   always_comb begin
      zero2_in = mag1_ff == '0;
      nrm2_in  = mag1_ff;
      lz2_in   = '0;
      if (nrm2_in[63:32] == '0) begin
         nrm2_in = nrm2_in << 32;
         lz2_in  = lz2_in + 6'd32;
      end
      if (nrm2_in[63:48] == '0) begin
         nrm2_in = nrm2_in << 16;
         lz2_in  = lz2_in + 6'd16;
      end
      if (nrm2_in[63:56] == '0) begin
         nrm2_in = nrm2_in << 8;
         lz2_in  = lz2_in + 6'd8;
      end
   end

   // fine normalize
   always_comb begin
      nrm3_in = nrm2_ff;
      lz3_in  = lz2_ff;
      if (nrm3_in[63:60] == '0) begin
         nrm3_in = nrm3_in << 4;
         lz3_in  = lz3_in + 6'd4;
      end
      if (nrm3_in[63:62] == '0) begin
         nrm3_in = nrm3_in << 2;
         lz3_in  = lz3_in + 6'd2;
      end
      if (!nrm3_in[63]) begin
         nrm3_in = nrm3_in << 1;
         lz3_in  = lz3_in + 6'd1;
      end
   end

   // round and pack
   always_comb begin
      expo    = EXP_TOP - {5'd0, lz3_ff};
      rnd     = nrm3_ff[10] & ((|nrm3_ff[9:0]) | nrm3_ff[11]);
      body    = {expo, nrm3_ff[62:11]} + {62'd0, rnd};
      dbl4_in = zero3_ff ? '0 : {sgn3_ff, body};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sgn1_ff  <= int_val[63];
         mag1_ff  <= int_val[63] ? (~int_val + 64'd1) : int_val;
         sgn2_ff  <= sgn1_ff;
         zero2_ff <= zero2_in;
         nrm2_ff  <= nrm2_in;
         lz2_ff   <= lz2_in;
         sgn3_ff  <= sgn2_ff;
         zero3_ff <= zero2_ff;
         nrm3_ff  <= nrm3_in;
         lz3_ff   <= lz3_in;
         dbl4_ff  <= dbl4_in;
      end
   end

   assign dbl_val = dbl4_ff;

endmodule

// ----- hdl/nflu_fadd.sv -----
// Six-stage IEEE double adder, round to nearest even, with subnormals and specials
module nflu_fadd import nflu_pkg::*; (
   input  logic     clock,
   input  logic     en,
   input  word_type a,
   input  word_type b,
   output word_type sum
);

   typedef struct packed {
      logic nan;
      logic inf;
      logic inf_sgn;
      logic eff_sub;
      logic s_big;
   } flags_type;

   logic        a_big, a_inf, b_inf;
   word_type    big, sml;
   logic [10:0] e_big, e_sml, diff;

   logic [52:0] s1_big_ff, s1_sml_ff;
   logic [10:0] s1_e_ff;
   logic [5:0]  s1_d_ff;
   flags_type   s1_flg_ff, s1_flg_in;

   logic [55:0] sml_ext, sml_sh, sml_mask, s2_al_in, s2_al_ff;
   logic [52:0] s2_big_ff;
   logic [10:0] s2_e_ff;
   flags_type   s2_flg_ff;

   logic [56:0] s3_sum_ff, s3_sum_in;
   logic [10:0] s3_e_ff;
   flags_type   s3_flg_ff;

   logic [55:0] s4_n_ff, s4_n_in;
   logic [11:0] s4_e_ff, s4_e_in;
   logic        s4_zero_ff;
   flags_type   s4_flg_ff;

   logic [55:0] s5_n_ff, s5_n_in;
   logic [11:0] s5_e_ff, s5_e_in;
   logic        s5_zero_ff;
   flags_type   s5_flg_ff;

   logic        rnd;
   logic [10:0] ef;
   logic [62:0] body;
   word_type    sum_ff, sum_in;

   // order by magnitude, unpack, flag specials
   always_comb begin
      a_big = a[62:0] >= b[62:0];
      big   = a_big ? a : b;
      sml   = a_big ? b : a;
      e_big = (big[62:52] == '0) ? 11'd1 : big[62:52];
      e_sml = (sml[62:52] == '0) ? 11'd1 : sml[62:52];
      diff  = e_big - e_sml;
      a_inf = a[62:0] == {EXP_MAX, 52'd0};
      b_inf = b[62:0] == {EXP_MAX, 52'd0};
      s1_flg_in.nan     = f_isnan(a) || f_isnan(b) || (a_inf && b_inf && (a[63] != b[63]));
      s1_flg_in.inf     = a_inf || b_inf;
      s1_flg_in.inf_sgn = a_inf ? a[63] : b[63];
      s1_flg_in.eff_sub = a[63] ^ b[63];
      s1_flg_in.s_big   = big[63];
   end

   // align the smaller operand, fold shifted-out bits into sticky
   always_comb begin
      sml_ext  = {s1_sml_ff, 3'b000};
      sml_sh   = sml_ext >> s1_d_ff;
      sml_mask = ~({56{1'b1}} << s1_d_ff);
      s2_al_in = {sml_sh[55:1], sml_sh[0] | (|(sml_ext & sml_mask))};
   end

   always_comb begin
      if (s2_flg_ff.eff_sub) begin
         s3_sum_in = {1'b0, s2_big_ff, 3'b000} - {1'b0, s2_al_ff};
      end else begin
         s3_sum_in = {1'b0, s2_big_ff, 3'b000} + {1'b0, s2_al_ff};
      end
   end

   // carry fix and coarse left normalize, never below the smallest exponent
   always_comb begin
      if (s3_sum_ff[56]) begin
         s4_n_in = {s3_sum_ff[56:2], s3_sum_ff[1] | s3_sum_ff[0]};
         s4_e_in = {1'b0, s3_e_ff} + 12'd1;
      end else begin
         s4_n_in = s3_sum_ff[55:0];
         s4_e_in = {1'b0, s3_e_ff};
      end
      if (s4_n_in[55:24] == '0 && s4_e_in > 12'd32) begin
         s4_n_in = s4_n_in << 32;
         s4_e_in = s4_e_in - 12'd32;
      end
      if (s4_n_in[55:40] == '0 && s4_e_in > 12'd16) begin
         s4_n_in = s4_n_in << 16;
         s4_e_in = s4_e_in - 12'd16;
      end
   end

   always_comb begin
      s5_n_in = s4_n_ff;
      s5_e_in = s4_e_ff;
      if (s5_n_in[55:48] == '0 && s5_e_in > 12'd8) begin
         s5_n_in = s5_n_in << 8;
         s5_e_in = s5_e_in - 12'd8;
      end
      if (s5_n_in[55:52] == '0 && s5_e_in > 12'd4) begin
         s5_n_in = s5_n_in << 4;
         s5_e_in = s5_e_in - 12'd4;
      end
      if (s5_n_in[55:54] == '0 && s5_e_in > 12'd2) begin
         s5_n_in = s5_n_in << 2;
         s5_e_in = s5_e_in - 12'd2;
      end
      if (!s5_n_in[55] && s5_e_in > 12'd1) begin
         s5_n_in = s5_n_in << 1;
         s5_e_in = s5_e_in - 12'd1;
      end
   end

   // round and pack; a carry out of the mantissa bumps the exponent
   always_comb begin
      rnd  = s5_n_ff[2] & (s5_n_ff[1] | s5_n_ff[0] | s5_n_ff[3]);
      ef   = s5_n_ff[55] ? s5_e_ff[10:0] : 11'd0;
      body = {ef, s5_n_ff[54:3]} + {62'd0, rnd};
      if (s5_flg_ff.nan) begin
         sum_in = DBL_QNAN;
      end else if (s5_flg_ff.inf) begin
         sum_in = {s5_flg_ff.inf_sgn, EXP_MAX, 52'd0};
      end else if (s5_zero_ff) begin
         sum_in = {!s5_flg_ff.eff_sub && s5_flg_ff.s_big, 63'd0};
      end else if (s5_e_ff >= {1'b0, EXP_MAX}) begin
         sum_in = {s5_flg_ff.s_big, EXP_MAX, 52'd0};
      end else begin
         sum_in = {s5_flg_ff.s_big, body};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_big_ff  <= {big[62:52] != '0, big[51:0]};
         s1_sml_ff  <= {sml[62:52] != '0, sml[51:0]};
         s1_e_ff    <= e_big;
         s1_d_ff    <= (diff > 11'd63) ? 6'd63 : diff[5:0];
         s1_flg_ff  <= s1_flg_in;
         s2_big_ff  <= s1_big_ff;
         s2_al_ff   <= s2_al_in;
         s2_e_ff    <= s1_e_ff;
         s2_flg_ff  <= s1_flg_ff;
         s3_sum_ff  <= s3_sum_in;
         s3_e_ff    <= s2_e_ff;
         s3_flg_ff  <= s2_flg_ff;
         s4_n_ff    <= s4_n_in;
         s4_e_ff    <= s4_e_in;
         s4_zero_ff <= s3_sum_ff == '0;
         s4_flg_ff  <= s3_flg_ff;
         s5_n_ff    <= s5_n_in;
         s5_e_ff    <= s5_e_in;
         s5_zero_ff <= s4_zero_ff;
         s5_flg_ff  <= s4_flg_ff;
         sum_ff     <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

// ----- hdl/nflu_div.sv -----
// Pipelined restoring unsigned divider, one quotient bit per stage, result carried alongside
module nflu_div import nflu_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     in_valid,
   input  word_type dividend,
   input  word_type divisor,
   input  side_type in_side,
   output logic     out_valid,
   output word_type quotient,
   output side_type out_side
);

   logic [DIV_STAGES-1:0] vld_ff;
   word_type              rem_ff  [DIV_STAGES];
   word_type              rem_in  [DIV_STAGES];
   word_type              nq_ff   [DIV_STAGES];
   word_type              nq_in   [DIV_STAGES];
   word_type              den_ff  [DIV_STAGES];
   side_type              side_ff [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      logic           vld_prev;
      word_type       rem_prev, nq_prev, den_prev;
      side_type       side_prev;
      logic [WORD_W:0] trial;
      logic           ge;

      if (s == 0) begin : g_head
         assign vld_prev  = in_valid;
         assign rem_prev  = '0;
         assign nq_prev   = dividend;
         assign den_prev  = divisor;
         assign side_prev = in_side;
      end else begin : g_body
         assign vld_prev  = vld_ff[s-1];
         assign rem_prev  = rem_ff[s-1];
         assign nq_prev   = nq_ff[s-1];
         assign den_prev  = den_ff[s-1];
         assign side_prev = side_ff[s-1];
      end

      // shift in the next dividend bit, subtract when it fits
      assign trial     = {rem_prev, nq_prev[WORD_W-1]};
      assign ge        = trial >= {1'b0, den_prev};
      assign rem_in[s] = ge ? WORD_W'(trial - {1'b0, den_prev}) : trial[WORD_W-1:0];
      assign nq_in[s]  = {nq_prev[WORD_W-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in[s];
            nq_ff[s]   <= nq_in[s];
            den_ff[s]  <= den_prev;
            side_ff[s] <= side_prev;
         end
      end
   end

   assign out_valid = vld_ff[DIV_STAGES-1];
   assign quotient  = nq_ff[DIV_STAGES-1];
   assign out_side  = side_ff[DIV_STAGES-1];

endmodule

// ----- hdl/nflu_checker.sv -----
// Port-level checker of the numeric for-loop unit and its bind
`include "numeric_for_loop_unit_assert.svh"

module nflu_checker import nflu_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_outcome,
   input logic [1:0]  rsp_new0_tag,
   input logic [1:0]  rsp_new1_tag,
   input logic [1:0]  rsp_new2_tag,
   input logic [63:0] rsp_new0_bits
);

   // a stalled response holds
   `NFLU_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_outcome) && $stable(rsp_new0_bits), "stalled response changed")

   // reset empties the pipeline
   `NFLU_ASSERT_RST(a_rsp_reset, clock, reset, !rsp_valid, "response valid after reset")

   // the skid fills only when a word is taken during an output stall
   `NFLU_ASSERT_IMP(a_skid_cause, clock, reset, !req_ready, $past(rsp_valid && !rsp_ready) && $past(req_valid || !req_ready), "request ready dropped without output stall")

   // an entered loop rewrites all three cells to one numeric type
   `NFLU_ASSERT_IMP(a_enter_tags, clock, reset, rsp_valid && rsp_outcome == OUT_ENTER, rsp_new0_tag == rsp_new1_tag && rsp_new1_tag == rsp_new2_tag && (rsp_new0_tag == TAG_INT || rsp_new0_tag == TAG_FLT), "entered loop with mixed cell tags")

endmodule

bind numeric_for_loop_unit nflu_checker u_nflu_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_outcome   (rsp_chan.outcome),
   .rsp_new0_tag  (rsp_chan.new0_tag),
   .rsp_new1_tag  (rsp_chan.new1_tag),
   .rsp_new2_tag  (rsp_chan.new2_tag),
   .rsp_new0_bits (rsp_chan.new0_bits)
);

// ----- sim/tb.sv -----
// Self-checking testbench for the numeric for-loop unit
`timescale 1ns / 1ps

module tb;
   import nflu_pkg::*;

   localparam int      LIMIT_CYCLES = 200000;
   localparam int      DRAIN_CYCLES = 90;
   localparam int      RAND_WORDS   = 1450;
   localparam tag_type TAG_OTHER    = 2'd2;
   localparam tag_type TAG_ODD      = 2'd3;

   // Handy integer and double payloads.
   localparam word_type I_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam word_type I_MIN   = 64'h8000_0000_0000_0000;
   localparam word_type I_NEG1  = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam word_type D_ONE   = 64'h3FF0_0000_0000_0000;
   localparam word_type D_HALF  = 64'h3FE0_0000_0000_0000;
   localparam word_type D_TEN   = 64'h4024_0000_0000_0000;
   localparam word_type D_MONE  = 64'hBFF0_0000_0000_0000;
   localparam word_type D_NZERO = 64'h8000_0000_0000_0000;
   localparam word_type D_INF   = 64'h7FF0_0000_0000_0000;
   localparam word_type D_NINF  = 64'hFFF0_0000_0000_0000;
   localparam word_type D_SNAN  = 64'h7FF0_0000_0000_0001;

   typedef struct packed {
      outcome_type           outcome;
      logic [2:0][1:0]       tag;
      logic [2:0][63:0]      bits;
   } loop_res_type;

   typedef struct packed {
      item_type     it;
      logic         typed;
      loop_res_type want;
   } loop_word_type;

   logic clock;
   logic reset;

   nflu_req_if req_if ();
   nflu_rsp_if rsp_if ();

   numeric_for_loop_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   loop_word_type stim_q[$];
   loop_res_type  loop_expect_q[$];
   int            cycles;
   int            errors;
   int            words_sent;
   int            words_seen;
   int            backs_seen;
   bit            stim_done;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Payload of a cell as double bits: convert integers, pass floats through untouched.
   function automatic word_type cell_dbits(tag_type t, word_type b);
      word_type r;
      if (t == TAG_INT) begin
         r = $realtobits(real'(longint'(b)));
      end else begin
         r = b;
      end
      return r;
   endfunction

   // Work out the outcome and the rewritten cells of one loop instruction.
   function automatic loop_res_type loop_predict(item_type it);
      loop_res_type r;
      longint       si, sl, ss;
      word_type     span, stride, dl, ds, di;
      real          iv, lv, sv, sum;
      r.outcome = OUT_REJ;
      r.tag  = {it.tag2, it.tag1, it.tag0};
      r.bits = {it.bits2, it.bits1, it.bits0};
      if (it.cmd == CMD_PREP) begin
         if (it.tag0 == TAG_INT && it.tag1 == TAG_INT && it.tag2 == TAG_INT) begin
            si = longint'(it.bits0);
            sl = longint'(it.bits1);
            ss = longint'(it.bits2);
            if (ss == 0) begin
               r.outcome = OUT_REJ;
            end else if ((ss > 0 && si > sl) || (ss < 0 && si < sl)) begin
               r.outcome = OUT_SKIP;
            end else begin
               span   = (ss > 0) ? it.bits1 - it.bits0 : it.bits0 - it.bits1;
               stride = (ss > 0) ? it.bits2 : 64'd0 - it.bits2;
               r.bits = {it.bits0, it.bits2, span / stride};
               r.outcome = OUT_ENTER;
            end
         end else if (it.tag0 <= TAG_FLT && it.tag1 <= TAG_FLT && it.tag2 <= TAG_FLT) begin
            di = cell_dbits(it.tag0, it.bits0);
            dl = cell_dbits(it.tag1, it.bits1);
            ds = cell_dbits(it.tag2, it.bits2);
            iv = $bitstoreal(di);
            lv = $bitstoreal(dl);
            sv = $bitstoreal(ds);
            if (sv == 0.0) begin
               r.outcome = OUT_REJ;
            end else if ((sv > 0.0 && lv < iv) || (sv < 0.0 && iv < lv)) begin
               r.outcome = OUT_SKIP;
            end else begin
               r.bits = {di, ds, dl};
               r.tag  = {TAG_FLT, TAG_FLT, TAG_FLT};
               r.outcome = OUT_ENTER;
            end
         end
      end else if (it.tag1 == TAG_INT) begin
         // integer loop: cell 0 is the remaining count whatever its tag
         if (it.bits0 != 64'd0) begin
            r.bits[0] = it.bits0 - 64'd1;
            r.bits[2] = it.bits2 + it.bits1;
            r.outcome = OUT_BACK;
         end else begin
            r.outcome = OUT_FALL;
         end
      end else begin
         lv  = $bitstoreal(it.bits0);
         sv  = $bitstoreal(it.bits1);
         sum = $bitstoreal(it.bits2) + sv;
         if ((sv > 0.0 && sum <= lv) || (sv < 0.0 && lv <= sum)) begin
            r.bits[2] = $realtobits(sum);
            r.outcome = OUT_BACK;
         end else begin
            r.outcome = OUT_FALL;
         end
      end
      return r;
   endfunction

   function automatic item_type mk_item(logic c, tag_type t0, word_type b0, tag_type t1,
                                        word_type b1, tag_type t2, word_type b2);
      item_type it;
      it = '{cmd: c, tag0: t0, bits0: b0, tag1: t1, bits1: b1, tag2: t2, bits2: b2};
      return it;
   endfunction

   // Queue a word; a typed outcome means the cells must come back unchanged.
   task automatic add_row(item_type it, logic typed, outcome_type oc);
      loop_word_type w;
      w.it    = it;
      w.typed = typed;
      w.want.outcome = oc;
      w.want.tag  = {it.tag2, it.tag1, it.tag0};
      w.want.bits = {it.bits2, it.bits1, it.bits0};
      stim_q.push_back(w);
   endtask

   function automatic tag_type pick_tag();
      int r;
      tag_type t;
      r = $urandom_range(0, 19);
      if (r < 11)       t = TAG_INT;
      else if (r < 18)  t = TAG_FLT;
      else if (r == 18) t = TAG_OTHER;
      else              t = TAG_ODD;
      return t;
   endfunction

   // Mostly small values so loops end, plus extremes and fully random payloads.
   function automatic word_type pick_bits(tag_type t);
      int       mode;
      word_type b;
      mode = $urandom_range(0, 9);
      if (mode == 6) begin
         if (t == TAG_INT) begin
            case ($urandom_range(0, 4))
               0: b = 64'd0;
               1: b = 64'd1;
               2: b = I_NEG1;
               3: b = I_MAX;
               default: b = I_MIN;
            endcase
         end else begin
            case ($urandom_range(0, 7))
               0: b = 64'd0;
               1: b = D_NZERO;
               2: b = D_INF;
               3: b = D_NINF;
               4: b = DBL_QNAN;
               5: b = D_SNAN;
               6: b = 64'h8000_0000_0000_0001;
               default: b = 64'h0000_0000_0000_0001;
            endcase
         end
      end else if (mode >= 7) begin
         b = {$urandom, $urandom};
      end else if (t == TAG_INT) begin
         b = word_type'(longint'($urandom_range(0, 40)) - 20);
      end else begin
         b = $realtobits((real'($urandom_range(0, 40)) - 20.0) / real'($urandom_range(1, 4)));
      end
      return b;
   endfunction

   // Directed table, then random loops: a prepare followed by its steps, fed back.
   task automatic build_stimulus();
      item_type     it;
      loop_res_type r;
      int           nsteps;
      add_row(mk_item(CMD_PREP, TAG_INT, 64'd1, TAG_INT, 64'd10, TAG_INT, 64'd1), 1'b0, OUT_ENTER);
      add_row(mk_item(CMD_PREP, TAG_INT, 64'd0, TAG_INT, 64'd0, TAG_INT, 64'd0), 1'b1, OUT_REJ);
      add_row(mk_item(CMD_PREP, TAG_INT, 64'd5, TAG_INT, 64'd1, TAG_INT, 64'd1), 1'b1, OUT_SKIP);
      add_row(mk_item(CMD_PREP, TAG_INT, 64'd1, TAG_INT, 64'd5, TAG_INT, I_NEG1), 1'b1, OUT_SKIP);
      add_row(mk_item(CMD_PREP, TAG_INT, I_MIN, TAG_INT, I_MAX, TAG_INT, 64'd1), 1'b0, OUT_ENTER);
      add_row(mk_item(CMD_PREP, TAG_INT, I_MAX, TAG_INT, I_MIN, TAG_INT, I_MIN), 1'b0, OUT_ENTER);
      add_row(mk_item(CMD_PREP, TAG_INT, 64'd0, TAG_INT, I_MAX, TAG_INT, I_MAX), 1'b0, OUT_ENTER);
      add_row(mk_item(CMD_PREP, TAG_OTHER, 64'd1, TAG_INT, 64'd5, TAG_INT, 64'd1), 1'b1, OUT_REJ);
      add_row(mk_item(CMD_PREP, TAG_INT, 64'd1, TAG_FLT, D_ONE, TAG_ODD, I_NEG1), 1'b1, OUT_REJ);
      add_row(mk_item(CMD_PREP, TAG_FLT, D_ONE, TAG_INT, 64'd10, TAG_FLT, D_HALF), 1'b0,
              OUT_ENTER);
      add_row(mk_item(CMD_PREP, TAG_FLT, D_ONE, TAG_FLT, D_TEN, TAG_FLT, D_NZERO), 1'b1, OUT_REJ);
      add_row(mk_item(CMD_PREP, TAG_FLT, DBL_QNAN, TAG_INT, 64'd3, TAG_INT, 64'd1), 1'b0,
              OUT_ENTER);
      add_row(mk_item(CMD_PREP, TAG_INT, 64'd0, TAG_FLT, D_ONE, TAG_FLT, DBL_QNAN), 1'b0,
              OUT_ENTER);
      add_row(mk_item(CMD_PREP, TAG_FLT, D_TEN, TAG_FLT, D_ONE, TAG_FLT, D_ONE), 1'b1, OUT_SKIP);
      add_row(mk_item(CMD_STEP, TAG_INT, 64'd0, TAG_INT, 64'd2, TAG_INT, 64'd7), 1'b1, OUT_FALL);
      add_row(mk_item(CMD_STEP, TAG_INT, 64'd3, TAG_INT, 64'd2, TAG_INT, I_MAX), 1'b0, OUT_BACK);
      add_row(mk_item(CMD_STEP, TAG_FLT, D_ONE, TAG_INT, I_NEG1, TAG_ODD, I_MIN), 1'b0, OUT_BACK);
      add_row(mk_item(CMD_STEP, TAG_FLT, D_ONE, TAG_FLT, D_HALF, TAG_FLT, D_HALF), 1'b0,
              OUT_BACK);
      add_row(mk_item(CMD_STEP, TAG_FLT, D_ONE, TAG_FLT, D_HALF, TAG_FLT, D_ONE), 1'b1, OUT_FALL);
      add_row(mk_item(CMD_STEP, TAG_FLT, D_ONE, TAG_FLT, DBL_QNAN, TAG_FLT, D_ONE), 1'b1,
              OUT_FALL);
      add_row(mk_item(CMD_STEP, TAG_FLT, D_NINF, TAG_FLT, D_MONE, TAG_FLT, 64'd0), 1'b0,
              OUT_BACK);
      add_row(mk_item(CMD_STEP, TAG_ODD, I_NEG1, TAG_ODD, I_NEG1, TAG_ODD, I_NEG1), 1'b0,
              OUT_FALL);
      while (stim_q.size() < RAND_WORDS + 22) begin
         it.cmd = ($urandom_range(0, 9) < 7) ? CMD_PREP : CMD_STEP;
         it.tag0 = pick_tag();
         it.tag1 = pick_tag();
         it.tag2 = pick_tag();
         it.bits0 = pick_bits(it.tag0);
         it.bits1 = pick_bits(it.tag1);
         it.bits2 = pick_bits(it.tag2);
         add_row(it, 1'b0, OUT_ENTER);
         r = loop_predict(it);
         if (it.cmd == CMD_PREP && r.outcome == OUT_ENTER) begin
            // walk the loop it set up, stopping early now and then
            nsteps = $urandom_range(1, 8);
            for (int s = 0; s < nsteps; s++) begin
               it = mk_item(CMD_STEP, r.tag[0], r.bits[0], r.tag[1], r.bits[1],
                            r.tag[2], r.bits[2]);
               add_row(it, 1'b0, OUT_ENTER);
               r = loop_predict(it);
               if (r.outcome == OUT_FALL) break;
            end
         end
      end
   endtask

   // Request side: hold each word until taken, idle between words at random.
   initial begin
      loop_word_type w;
      int            gap;
      bit            calm;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.cmd = 1'b0;
      req_if.cell0_tag = '0;
      req_if.cell0_bits = '0;
      req_if.cell1_tag = '0;
      req_if.cell1_bits = '0;
      req_if.cell2_tag = '0;
      req_if.cell2_bits = '0;
      stim_done = 1'b0;
      words_sent = 0;
      build_stimulus();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      calm = 1'b0;
      while (stim_q.size() > 0) begin
         w = stim_q.pop_front();
         if (words_sent % 64 == 0) calm = ($urandom_range(0, 3) == 0);
         gap = calm ? 0 : $urandom_range(0, 7);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_if.valid      <= 1'b1;
         req_if.cmd        <= w.it.cmd;
         req_if.cell0_tag  <= w.it.tag0;
         req_if.cell0_bits <= w.it.bits0;
         req_if.cell1_tag  <= w.it.tag1;
         req_if.cell1_bits <= w.it.bits1;
         req_if.cell2_tag  <= w.it.tag2;
         req_if.cell2_bits <= w.it.bits2;
         do @(posedge clock); while (!req_if.ready);
         // taken at this edge: predict now, in acceptance order
         loop_expect_q.push_back(w.typed ? w.want : loop_predict(w.it));
         words_sent++;
      end
      req_if.valid <= 1'b0;
      stim_done = 1'b1;
   end

   // Response side: stall at random, then compare each word with the oldest prediction.
   initial begin
      loop_res_type got, want;
      int           gap;
      bit           calm;
      errors = 0;
      words_seen = 0;
      backs_seen = 0;
      calm = 1'b0;
      rsp_if.ready = 1'b0;
      @(negedge reset);
      forever begin
         if (words_seen % 50 == 0) calm = ($urandom_range(0, 3) == 0);
         gap = calm ? 0 : $urandom_range(0, 7);
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
         got.outcome = outcome_type'(rsp_if.outcome);
         got.tag  = {rsp_if.new2_tag, rsp_if.new1_tag, rsp_if.new0_tag};
         got.bits = {rsp_if.new2_bits, rsp_if.new1_bits, rsp_if.new0_bits};
         words_seen++;
         if (got.outcome == OUT_BACK) backs_seen++;
         if (loop_expect_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, expected none, actual outcome %0d",
                     $time, got.outcome);
         end else begin
            want = loop_expect_q.pop_front();
            if (got.outcome !== want.outcome) begin
               errors++;
               $display("%0t: outcome expected %0d actual %0d",
                        $time, want.outcome, got.outcome);
            end
            for (int k = 0; k < 3; k++) begin
               if (got.tag[k] !== want.tag[k]) begin
                  errors++;
                  $display("%0t: new%0d_tag expected %0d actual %0d",
                           $time, k, want.tag[k], got.tag[k]);
               end
               if (got.bits[k] !== want.bits[k]) begin
                  errors++;
                  $display("%0t: new%0d_bits expected %h actual %h",
                           $time, k, want.bits[k], got.bits[k]);
               end
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run here.
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycles, loop_expect_q.size());
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // Wrap up: drain every outstanding word, then give the pipeline time to go quiet.
   initial begin
      wait (stim_done);
      while (loop_expect_q.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d loop words (%0d back edges), prepare and step, int and float",
               words_seen, backs_seen);
      $display("%0d words sent, %0d field mismatches", words_sent, errors);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
